FILE: rtl/ffcsa_pkg.sv
// ----------------------------------------------------------------------------
// ffcsa_pkg
// shared widths, codes and types of the first-fit slot allocator
// ----------------------------------------------------------------------------
package ffcsa_pkg;

  localparam int SLOTS_DEF = 1024;

  localparam int OP_W     = 2;
  localparam int TAG_W    = 14;
  localparam int LEN_W    = 11;
  localparam int IDX_W    = 10;
  localparam int STATUS_W = 3;
  localparam int START_W  = 10;
  localparam int REV_W    = 32;
  localparam int FEE_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ALLOC    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOROOM   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEE          = 1'd1;

  localparam logic [TAG_W-1:0]  TAG_MIN     = 14'd1000;
  localparam logic [TAG_W-1:0]  TAG_MAX     = 14'd9999;
  localparam logic [LEN_W-1:0]  SLOTS_RESET = 11'd1024;
  localparam logic [FEE_W-1:0]  FEE_RESET   = 8'd10;

  typedef struct packed {
    logic             shift;
    logic [TAG_W-1:0] feed;
  } ring_ctl_t;

endpackage

FILE: rtl/ffcsa_req_if.sv
// ----------------------------------------------------------------------------
// ffcsa_req_if
// request channel of the slot allocator
// ----------------------------------------------------------------------------
interface ffcsa_req_if;
  import ffcsa_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [TAG_W-1:0] owner_id;
  logic [LEN_W-1:0] block_length;
  logic [IDX_W-1:0] slot_index;

  modport source (output valid, opcode, owner_id, block_length, slot_index, input ready);
  modport sink   (input valid, opcode, owner_id, block_length, slot_index, output ready);
endinterface

FILE: rtl/ffcsa_rsp_if.sv
// ----------------------------------------------------------------------------
// ffcsa_rsp_if
// result channel of the slot allocator
// ----------------------------------------------------------------------------
interface ffcsa_rsp_if;
  import ffcsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [START_W-1:0]  start_index;
  logic [TAG_W-1:0]    slot_owner;
  logic [REV_W-1:0]    revenue;

  modport source (output valid, status, start_index, slot_owner, revenue, input ready);
  modport sink   (input valid, status, start_index, slot_owner, revenue, output ready);
endinterface

FILE: rtl/ffcsa_cfg_if.sv
// ----------------------------------------------------------------------------
// ffcsa_cfg_if
// configuration write channel of the slot allocator
// ----------------------------------------------------------------------------
interface ffcsa_cfg_if;
  import ffcsa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/ffcsa_cell.sv
// ----------------------------------------------------------------------------
// ffcsa_cell
// one slot of the tag ring, takes its neighbor's tag on every shift
// ----------------------------------------------------------------------------
module ffcsa_cell import ffcsa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift,
  input  logic [TAG_W-1:0] d,
  output logic [TAG_W-1:0] q
);

  logic [TAG_W-1:0] tag_r;
  logic [TAG_W-1:0] tag_nxt;

  assign tag_nxt = shift ? d : tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_nxt;
    end
  end

  assign q = tag_r;

endmodule

FILE: rtl/ffcsa_ctrl.sv
// ----------------------------------------------------------------------------
// ffcsa_ctrl
// request sequencer at the head of the tag ring, config and result register
// ----------------------------------------------------------------------------
module ffcsa_ctrl import ffcsa_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  ffcsa_req_if.sink        in_chan,
  ffcsa_rsp_if.source      out_chan,
  ffcsa_cfg_if.sink        cfg_chan,
  input  logic [TAG_W-1:0] head_tag,
  output ring_ctl_t        ring_ctl
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CW     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [SLOT_W-1:0] LAST_K = SLOT_W'(SLOTS - 1);
  localparam logic [CW-1:0]     N_MAX  = CW'(SLOTS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PASS1 = 4'b0010,
    S_PASS2 = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   k_r, k_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [TAG_W-1:0]    tag_r, tag_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]       run_r, run_nxt;
  logic                fit_r, fit_nxt;
  logic                dup_r, dup_nxt;
  logic                found_r, found_nxt;
  logic [CW-1:0]       lo_r, lo_nxt;
  logic [CW-1:0]       hi_r, hi_nxt;
  logic [TAG_W-1:0]    owner_r, owner_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [REV_W-1:0]    rev_r, rev_nxt;
  logic [LEN_W-1:0]    slots_r;
  logic [FEE_W-1:0]    fee_r;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [START_W-1:0]  out_start_r;
  logic [TAG_W-1:0]    out_owner_r;
  logic [REV_W-1:0]    out_rev_r;
  logic                out_load;

  logic [CW-1:0]       slots_ext;
  logic [CW-1:0]       n_eff;
  logic [CW-1:0]       kx;
  logic [CW-1:0]       len_ext;
  logic                in_rng;
  logic                tag_ok;
  logic                in_tag_ok;
  logic [REV_W:0]      rev_sum;
  logic [TAG_W-1:0]    feed;

  assign slots_ext = CW'(slots_r);
  assign n_eff     = (slots_ext == '0) ? CW'(1) : ((slots_ext > N_MAX) ? N_MAX : slots_ext);
  assign kx        = CW'(k_r);
  assign len_ext   = CW'(len_r);
  assign in_rng    = (kx < n_eff);
  assign tag_ok    = (tag_r >= TAG_MIN) && (tag_r <= TAG_MAX);
  assign in_tag_ok = (in_chan.owner_id >= TAG_MIN) && (in_chan.owner_id <= TAG_MAX);
  assign rev_sum   = {1'b0, rev_r} + (REV_W + 1)'(fee_r);

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_load       = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    op_nxt     = op_r;
    tag_nxt    = tag_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    run_nxt    = run_r;
    fit_nxt    = fit_r;
    dup_nxt    = dup_r;
    found_nxt  = found_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    owner_nxt  = owner_r;
    status_nxt = status_r;
    rev_nxt    = rev_r;
    feed       = head_tag;

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt    = in_chan.opcode;
          tag_nxt   = in_chan.owner_id;
          len_nxt   = in_chan.block_length;
          idx_nxt   = in_chan.slot_index;
          k_nxt     = '0;
          run_nxt   = '0;
          fit_nxt   = 1'b0;
          dup_nxt   = 1'b0;
          found_nxt = 1'b0;
          lo_nxt    = '0;
          hi_nxt    = '0;
          owner_nxt = '0;
          status_nxt = ST_INVALID;
          state_nxt  = S_DONE;
          unique case (in_chan.opcode)
            OP_ALLOC: begin
              if (in_tag_ok && (in_chan.block_length != '0)) state_nxt = S_PASS1;
            end
            OP_RELEASE: begin
              if (in_tag_ok) state_nxt = S_PASS1;
            end
            OP_READ: begin
              if (CW'(in_chan.slot_index) < n_eff) state_nxt = S_PASS1;
            end
            OP_UNUSED: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_PASS1: begin
        unique case (op_r)
          OP_ALLOC: begin
            if (in_rng) begin
              if (head_tag == tag_r) dup_nxt = 1'b1;
              if (!fit_r) begin
                if (head_tag == '0) begin
                  run_nxt = run_r + CW'(1);
                  if ((run_r + CW'(1)) == len_ext) begin
                    fit_nxt = 1'b1;
                    lo_nxt  = kx + CW'(1) - len_ext;
                    hi_nxt  = kx;
                  end
                end else begin
                  run_nxt = '0;
                end
              end
            end
          end
          OP_RELEASE: begin
            if (in_rng && (head_tag == tag_r)) begin
              feed      = '0;
              found_nxt = 1'b1;
            end
          end
          OP_READ: begin
            if (kx == CW'(idx_r)) owner_nxt = head_tag;
          end
          OP_UNUSED: begin
            feed = head_tag;
          end
        endcase

        k_nxt = k_r + SLOT_W'(1);
        if (k_r == LAST_K) begin
          k_nxt     = '0;
          state_nxt = S_DONE;
          unique case (op_r)
            OP_ALLOC: begin
              if (dup_nxt) begin
                status_nxt = ST_DUP;
              end else if (fit_nxt) begin
                status_nxt = ST_ALLOC;
                state_nxt  = S_PASS2;
                rev_nxt    = rev_sum[REV_W] ? {REV_W{1'b1}} : rev_sum[REV_W-1:0];
              end else begin
                status_nxt = ST_NOROOM;
              end
            end
            OP_RELEASE: status_nxt = found_nxt ? ST_REL : ST_NOTFOUND;
            OP_READ:    status_nxt = ST_READ;
            OP_UNUSED:  status_nxt = ST_INVALID;
          endcase
        end
      end

      S_PASS2: begin
        if ((kx >= lo_r) && (kx <= hi_r) && tag_ok) feed = tag_r;
        k_nxt = k_r + SLOT_W'(1);
        if (k_r == LAST_K) begin
          k_nxt     = '0;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign ring_ctl.shift = (state_r == S_PASS1) || (state_r == S_PASS2);
  assign ring_ctl.feed  = feed;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) out_valid_nxt = 1'b0;
    if (out_load)       out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rev_r       <= '0;
      slots_r     <= SLOTS_RESET;
      fee_r       <= FEE_RESET;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      if (cfg_chan.valid) begin
        unique case (cfg_chan.index)
          CFG_SLOTS_IN_USE: slots_r <= cfg_chan.data;
          CFG_FEE:          fee_r   <= cfg_chan.data[FEE_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    tag_r    <= tag_nxt;
    len_r    <= len_nxt;
    idx_r    <= idx_nxt;
    run_r    <= run_nxt;
    fit_r    <= fit_nxt;
    dup_r    <= dup_nxt;
    found_r  <= found_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    owner_r  <= owner_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_start_r  <= (status_r == ST_ALLOC) ? lo_r[START_W-1:0] : '0;
      out_owner_r  <= owner_r;
      out_rev_r    <= rev_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.start_index = out_start_r;
  assign out_chan.slot_owner  = out_owner_r;
  assign out_chan.revenue     = out_rev_r;

endmodule

FILE: rtl/first_fit_contiguous_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_contiguous_slot_allocator_unit
// first-fit allocator of contiguous owner-tagged slots with fee revenue
// ----------------------------------------------------------------------------
// The slot tags live in a ring of SLOTS cells that rotates one place per
// cycle past a sequencer at its head while a request is being worked on, so
// every request that passes the up-front checks is served by whole
// revolutions of the ring. An allocate takes one revolution for the duplicate
// check and first-fit search and one to write the run; when no run is written
// the result comes after the first revolution. Release and read take the
// first revolution only; a request rejected up front answers without turning
// the ring. One request is worked on at a time; the next one is taken as soon
// as the result is in the output register. All slots clear at reset.
module first_fit_contiguous_slot_allocator_unit import ffcsa_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ffcsa_req_if.sink   in_chan,
  ffcsa_rsp_if.source out_chan,
  ffcsa_cfg_if.sink   cfg_chan
);

  ring_ctl_t        ring_ctl;
  logic [TAG_W-1:0] ring_q [SLOTS];

  ffcsa_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan),
    .head_tag (ring_q[0]),
    .ring_ctl (ring_ctl)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic [TAG_W-1:0] d;
    if (i == SLOTS - 1) begin : g_tail
      assign d = ring_ctl.feed;
    end else begin : g_body
      assign d = ring_q[i+1];
    end
    ffcsa_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (ring_ctl.shift),
      .d     (d),
      .q     (ring_q[i])
    );
  end

endmodule

FILE: rtl/ffcsa_checker.sv
// ----------------------------------------------------------------------------
// ffcsa_checker
// port-level checks of the slot allocator
// ----------------------------------------------------------------------------
module ffcsa_checker import ffcsa_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [START_W-1:0]  start_index,
  input logic [TAG_W-1:0]    slot_owner,
  input logic [REV_W-1:0]    revenue
);

  logic [REV_W-1:0] last_rev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rev_r <= '0;
    end else if (out_valid && out_ready) begin
      last_rev_r <= revenue;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(revenue))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_ALLOC) |-> start_index == '0)
    else $error("start index set without allocation");

  a_owner_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_READ) |-> slot_owner == '0)
    else $error("slot owner set without read");

  a_rev_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> revenue >= last_rev_r)
    else $error("revenue went down");

endmodule

bind first_fit_contiguous_slot_allocator_unit ffcsa_checker u_ffcsa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .status      (out_chan.status),
  .start_index (out_chan.start_index),
  .slot_owner  (out_chan.slot_owner),
  .revenue     (out_chan.revenue)
);
